### design/tte_pkg.sv
// Shared constants, types and helpers for the tap tempo estimator.
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int TIME_W = 32;
    localparam int BPM_W  = 24;
    localparam int CFG_W  = 12;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_SECONDS = 2'd1;

    localparam int SS_W = 7;
    localparam int RS_W = 12;

    localparam logic [BPM_W-1:0] BPM_MAX       = {BPM_W{1'b1}};
    localparam logic [19:0]      US_PER_SECOND = 20'd1000000;
    // 60 s * 1e6 us * 256 (Q8 scaling)
    localparam logic [63:0]      BPM_NUM_UNIT  = 64'd15360000000;
    localparam int NUM_W = $clog2(BPM_NUM_UNIT * HISTORY_DEPTH + 1);

    localparam logic [CNT_W-1:0]  WINDOW_RST = CNT_W'((HISTORY_DEPTH < 5) ? HISTORY_DEPTH : 5);
    localparam logic [TIME_W-1:0] LIMIT_RST  = TIME_W'(5 * 1000000);

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [BPM_W-1:0] quot;
    } div_res_t;

    // Circular pointer add, both operands below HISTORY_DEPTH.
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                  input logic [PTR_W-1:0] d);
        logic [PTR_W:0] s;
        s = {1'b0, p} + {1'b0, d};
        if (s >= (PTR_W+1)'(HISTORY_DEPTH)) begin
            s = s - (PTR_W+1)'(HISTORY_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/tte_hist_mem.sv
// Tap time history memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tte_hist_mem (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [tte_pkg::PTR_W-1:0]   wr_addr,
    input  wire logic [tte_pkg::TIME_W-1:0]  wr_data,
    input  wire logic [tte_pkg::PTR_W-1:0]   rd_addr,
    output logic      [tte_pkg::TIME_W-1:0]  rd_data
);
    import tte_pkg::*;

    logic [TIME_W-1:0] mem [HISTORY_DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/tte_divider.sv
// Restoring divider, one quotient bit per cycle, with up-front saturation check.
`timescale 1ns / 1ps
`default_nettype none

module tte_divider (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [tte_pkg::NUM_W-1:0]   num,
    input  wire logic [tte_pkg::TIME_W-1:0]  den,
    output tte_pkg::div_res_t                res
);
    import tte_pkg::*;

    localparam int STEP_W = $clog2(BPM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              sat_reg,  sat_next;
    logic [BPM_W-1:0]  quot_reg, quot_next;
    logic [TIME_W-1:0] rem_reg,  rem_next;
    logic [BPM_W-1:0]  low_reg,  low_next;
    logic [TIME_W-1:0] den_reg,  den_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [TIME_W+BPM_W-1:0] den_shift;
    logic [TIME_W+BPM_W-1:0] num_ext;
    logic                    ovf;
    logic [TIME_W:0]         trial;
    logic                    ge;

    assign den_shift = {den, {BPM_W{1'b0}}};
    assign num_ext   = (TIME_W+BPM_W)'(num);
    // quotient would not fit in BPM_W bits
    assign ovf       = (num_ext >= den_shift);
    assign trial     = {rem_reg, low_reg[BPM_W-1]};
    assign ge        = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        step_next = step_reg;
        if (busy_reg) begin
            rem_next  = ge ? TIME_W'(trial - {1'b0, den_reg}) : trial[TIME_W-1:0];
            quot_next = {quot_reg[BPM_W-2:0], ge};
            low_next  = {low_reg[BPM_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(BPM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            den_next  = den;
            quot_next = '0;
            step_next = '0;
            if (den == '0 || ovf) begin
                sat_next  = 1'b1;
                done_next = 1'b1;
            end else begin
                sat_next  = 1'b0;
                busy_next = 1'b1;
                rem_next  = TIME_W'(num >> BPM_W);
                low_next  = num[BPM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        sat_reg  <= sat_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        den_reg  <= den_next;
        step_reg <= step_next;
    end

    assign res.done = done_reg;
    assign res.sat  = sat_reg;
    assign res.quot = quot_reg;

endmodule

`default_nettype wire

### design/tap_tempo_bpm_estimator.sv
// Tap tempo estimator top level: sequencer, history pointers, output register.
//
// Input channel (s_valid/s_ready/s_tap_time): one transfer per tap, carrying a
// free-running microsecond timestamp. The block takes one tap at a time;
// s_ready is high only while the sequencer is idle.
// Result channel (m_valid/m_ready/m_*): exactly one transfer per tap with the
// tempo in unsigned Q16.8 (60e6*256*k / elapsed), the interval count k and
// flags for timeout clear and saturation.
// Config port (cfg_wen/cfg_index/cfg_wdata): index 0 is sample_size, index 1
// is reset_seconds; write only while no tap is in flight. Other indexes drop.
// A tap passes CHECK, READ, CALC, DIV and DONE. DIV is skipped with no
// earlier tap; the divider saturates at once on zero elapsed time or
// overflow, else its 24-step restoring division runs. The next tap is
// taken only once the block is back in idle.
// The result sits in an output register: a stalled receiver holds the result
// while the next tap is already accepted and processed; that tap waits in the
// final step until the output register frees up.
// Reset (aresetn low, synchronous) empties the history and restores
// sample_size = 5 and reset_seconds = 5. The history RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module tap_tempo_bpm_estimator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // tap input
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [tte_pkg::TIME_W-1:0]    s_tap_time,
    // result output
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [tte_pkg::BPM_W-1:0]     m_bpm_q8,
    output logic                               m_bpm_valid,
    output logic                               m_history_cleared,
    output logic      [6:0]                    m_interval_count,
    output logic                               m_saturated,
    // configuration
    input  wire logic                          cfg_wen,
    input  wire logic [tte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tte_pkg::CFG_W-1:0]     cfg_wdata
);
    import tte_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;  // timeout test, optional clear
    localparam logic [2:0] ST_READ  = 3'd2;  // oldest entry read, numerator
    localparam logic [2:0] ST_CALC  = 3'd3;  // elapsed, kick divider
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;  // history update, result out

    // ---------------- configuration ----------------
    // Both registers are kept in the form the datapath uses: a clamped
    // window and the timeout in microseconds.
    logic [CNT_W-1:0]  window_reg;
    logic [TIME_W-1:0] limit_reg;
    logic [SS_W-1:0]   cfg_ss;
    logic [RS_W-1:0]   cfg_rs;

    assign cfg_ss = cfg_wdata[SS_W-1:0];
    assign cfg_rs = (cfg_wdata[RS_W-1:0] == '0) ? RS_W'(1) : cfg_wdata[RS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RST;
            limit_reg  <= LIMIT_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_SAMPLE_SIZE: begin
                    if (cfg_ss == '0) begin
                        window_reg <= CNT_W'(1);
                    end else if (32'(cfg_ss) > 32'(HISTORY_DEPTH)) begin
                        window_reg <= CNT_W'(HISTORY_DEPTH);
                    end else begin
                        window_reg <= CNT_W'(cfg_ss);
                    end
                end
                CFG_RESET_SECONDS: begin
                    limit_reg <= TIME_W'(cfg_rs) * TIME_W'(US_PER_SECOND);
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- sequencer and history state ----------------
    logic [2:0]        state_reg,   state_next;
    logic [PTR_W-1:0]  ptr_reg,     ptr_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [TIME_W-1:0] newest_reg,  newest_next;
    logic              m_valid_reg, m_valid_next;

    // per-tap working registers
    logic [TIME_W-1:0] now_reg,     now_next;
    logic [CNT_W-1:0]  k_reg,       k_next;
    logic [NUM_W-1:0]  num_reg,     num_next;
    logic              cleared_reg, cleared_next;
    logic              sat_reg,     sat_next;
    logic [BPM_W-1:0]  bpm_reg,     bpm_next;

    // output payload
    logic [BPM_W-1:0]  out_bpm_reg,     out_bpm_next;
    logic              out_valid_reg,   out_valid_next;
    logic              out_cleared_reg, out_cleared_next;
    logic [6:0]        out_count_reg,   out_count_next;
    logic              out_sat_reg,     out_sat_next;

    logic [TIME_W-1:0] rd_data;
    logic [TIME_W-1:0] gap;
    logic              div_start;
    div_res_t          div_res;
    logic              out_free;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;

    // history update terms
    logic              full;
    logic [PTR_W-1:0]  p1;
    logic [CNT_W-1:0]  c1;
    logic [CNT_W-1:0]  c2;
    logic [CNT_W-1:0]  surplus;
    logic [31:0]       k_ext;

    assign gap      = now_reg - newest_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Full history drops the oldest entry before the append; afterwards the
    // oldest surplus beyond the window goes in one pointer step.
    assign full    = (count_reg == CNT_W'(HISTORY_DEPTH));
    assign p1      = full ? wrap_add(ptr_reg, PTR_W'(1)) : ptr_reg;
    assign c1      = full ? CNT_W'(HISTORY_DEPTH - 1) : count_reg;
    assign wr_addr = wrap_add(p1, c1[PTR_W-1:0]);
    assign c2      = c1 + 1'b1;
    assign surplus = c2 - window_reg;
    assign k_ext   = 32'(k_reg);

    always_comb begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        count_next       = count_reg;
        newest_next      = newest_reg;
        m_valid_next     = m_valid_reg;
        now_next         = now_reg;
        k_next           = k_reg;
        num_next         = num_reg;
        cleared_next     = cleared_reg;
        sat_next         = sat_reg;
        bpm_next         = bpm_reg;
        out_bpm_next     = out_bpm_reg;
        out_valid_next   = out_valid_reg;
        out_cleared_next = out_cleared_reg;
        out_count_next   = out_count_reg;
        out_sat_next     = out_sat_reg;
        div_start        = 1'b0;
        wr_en            = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    now_next   = s_tap_time;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cleared_next = 1'b0;
                if (count_reg != '0 && gap > limit_reg) begin
                    count_next   = '0;
                    ptr_next     = '0;
                    cleared_next = 1'b1;
                end
                state_next = ST_READ;
            end
            ST_READ: begin
                // RAM read of the oldest entry is in flight this cycle
                k_next     = count_reg;
                num_next   = NUM_W'(BPM_NUM_UNIT * 64'(count_reg));
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (k_reg == '0) begin
                    bpm_next   = '0;
                    sat_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    sat_next   = div_res.sat;
                    bpm_next   = div_res.sat ? BPM_MAX : div_res.quot;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    wr_en       = 1'b1;
                    newest_next = now_reg;
                    if (c2 > window_reg) begin
                        ptr_next   = wrap_add(p1, surplus[PTR_W-1:0]);
                        count_next = window_reg;
                    end else begin
                        ptr_next   = p1;
                        count_next = c2;
                    end
                    m_valid_next     = 1'b1;
                    out_bpm_next     = bpm_reg;
                    out_valid_next   = (k_reg != '0);
                    out_cleared_next = cleared_reg;
                    out_count_next   = k_ext[6:0];
                    out_sat_next     = sat_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            count_reg   <= '0;
            newest_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            count_reg   <= count_next;
            newest_reg  <= newest_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg         <= now_next;
        k_reg           <= k_next;
        num_reg         <= num_next;
        cleared_reg     <= cleared_next;
        sat_reg         <= sat_next;
        bpm_reg         <= bpm_next;
        out_bpm_reg     <= out_bpm_next;
        out_valid_reg   <= out_valid_next;
        out_cleared_reg <= out_cleared_next;
        out_count_reg   <= out_count_next;
        out_sat_reg     <= out_sat_next;
    end

    // ---------------- submodules ----------------
    tte_hist_mem u_hist (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (now_reg),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // elapsed time since the oldest stored tap, modulo 2^32
    tte_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (now_reg - rd_data),
        .res     (div_res)
    );

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_bpm_q8          = out_bpm_reg;
    assign m_bpm_valid       = out_valid_reg;
    assign m_history_cleared = out_cleared_reg;
    assign m_interval_count  = out_count_reg;
    assign m_saturated       = out_sat_reg;

endmodule

`default_nettype wire

### test/tte_tempo_checker.sv
// Tap tempo checker: predicts the tempo result of each tap and compares the result channel.
`timescale 1ns / 1ps

module tte_tempo_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [tte_pkg::TIME_W-1:0]    s_tap_time,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [tte_pkg::BPM_W-1:0]     m_bpm_q8,
    input  wire logic                          m_bpm_valid,
    input  wire logic                          m_history_cleared,
    input  wire logic [6:0]                    m_interval_count,
    input  wire logic                          m_saturated,
    input  wire logic                          cfg_wen,
    input  wire logic [tte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tte_pkg::CFG_W-1:0]     cfg_wdata,
    output int                                 n_errors,
    output int                                 n_pending,
    output int                                 n_taps,
    output int                                 n_sat,
    output int                                 n_clear
);

    localparam int          DEPTH      = tte_pkg::HISTORY_DEPTH;
    localparam logic [63:0] BEAT_SCALE = 64'd15360000000;  // 60 s * 1e6 us * 256
    localparam logic [63:0] US_PER_S   = 64'd1000000;
    localparam logic [23:0] BPM_TOP    = 24'hFF_FFFF;

    typedef struct packed {
        logic [23:0] bpm;
        logic        bpm_ok;
        logic        cleared;
        logic [6:0]  intervals;
        logic        sat;
    } tempo_t;

    logic [31:0] tap_log [DEPTH];
    int unsigned head;
    int unsigned stored;
    logic [31:0] latest;
    logic [6:0]  window_reg;
    logic [11:0] timeout_reg;
    tempo_t      tempo_due [$];
    int          errs   = 0;
    int          taps   = 0;
    int          sats   = 0;
    int          clears = 0;

    function automatic void drop_oldest_tap();
        if (stored > 0) begin
            head = (head + 1) % DEPTH;
            stored--;
        end
    endfunction

    function automatic tempo_t tempo_of_tap(input logic [31:0] now);
        tempo_t      r;
        int unsigned win;
        logic [63:0] limit_us;
        logic [31:0] since;
        logic [31:0] span;
        logic [63:0] q;
        r = '0;
        win = (window_reg == 0) ? 1 : window_reg;
        if (win > DEPTH) begin
            win = DEPTH;
        end
        limit_us = 64'((timeout_reg == 0) ? 12'd1 : timeout_reg) * US_PER_S;
        since = now - latest;
        if (stored > 0 && {32'd0, since} > limit_us) begin
            stored    = 0;
            head      = 0;
            r.cleared = 1'b1;
        end
        r.intervals = 7'(stored);
        if (stored > 0) begin
            span     = now - tap_log[head];
            r.bpm_ok = 1'b1;
            if (span == 0) begin
                r.sat = 1'b1;
            end else begin
                q = (BEAT_SCALE * 64'(stored)) / {32'd0, span};
                if (q > {40'd0, BPM_TOP}) begin
                    r.sat = 1'b1;
                end else begin
                    r.bpm = q[23:0];
                end
            end
            if (r.sat) begin
                r.bpm = BPM_TOP;
            end
        end
        // full history: oldest goes before the new tap lands
        if (stored >= DEPTH) begin
            drop_oldest_tap();
        end
        tap_log[(head + stored) % DEPTH] = now;
        stored++;
        latest = now;
        while (stored > win) begin
            drop_oldest_tap();
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endfunction

    always @(posedge aclk) begin
        tempo_t want;
        tempo_t got;
        if (!aresetn) begin
            head        = 0;
            stored      = 0;
            latest      = '0;
            window_reg  = 7'd5;
            timeout_reg = 12'd5;
            tempo_due.delete();
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    tte_pkg::CFG_SAMPLE_SIZE:   window_reg  = cfg_wdata[6:0];
                    tte_pkg::CFG_RESET_SECONDS: timeout_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = {m_bpm_q8, m_bpm_valid, m_history_cleared, m_interval_count,
                       m_saturated};
                if (tempo_due.size() == 0) begin
                    $error("result transfer with no tap waiting");
                    errs++;
                end else begin
                    want = tempo_due.pop_front();
                    check_field("bpm_q8", want.bpm, got.bpm);
                    check_field("bpm_valid", want.bpm_ok, got.bpm_ok);
                    check_field("history_cleared", want.cleared, got.cleared);
                    check_field("interval_count", want.intervals, got.intervals);
                    check_field("saturated", want.sat, got.sat);
                end
            end
            if (s_valid && s_ready) begin
                want = tempo_of_tap(s_tap_time);
                tempo_due.push_back(want);
                taps++;
                if (want.sat) begin
                    sats++;
                end
                if (want.cleared) begin
                    clears++;
                end
            end
        end
        n_errors  <= errs;
        n_pending <= tempo_due.size();
        n_taps    <= taps;
        n_sat     <= sats;
        n_clear   <= clears;
    end

endmodule

### test/tb_tap_tempo_bpm_estimator.sv
// Testbench top for the tap tempo estimator: clock, reset, tap stimulus and verdict.
`timescale 1ns / 1ps

module tb_tap_tempo_bpm_estimator;

    // Indexes outside the register map; writes to them must be dropped.
    localparam logic [tte_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [tte_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                          aclk    = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [tte_pkg::TIME_W-1:0]    s_tap_time;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [tte_pkg::BPM_W-1:0]     m_bpm_q8;
    logic                          m_bpm_valid;
    logic                          m_history_cleared;
    logic [6:0]                    m_interval_count;
    logic                          m_saturated;
    logic                          cfg_wen;
    logic [tte_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tte_pkg::CFG_W-1:0]     cfg_wdata;

    int n_errors;
    int n_pending;
    int n_taps;
    int n_sat;
    int n_clear;

    bit          idle_on  = 1'b1;   // random gaps/stalls enabled
    int          rx_hold  = 0;      // cycles left in the current m_ready run
    int          settings = 0;      // register settings applied so far
    logic [31:0] clear_us;          // current timeout window in us

    always #4 aclk = ~aclk;

    tap_tempo_bpm_estimator u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_tap_time        (s_tap_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_bpm_q8          (m_bpm_q8),
        .m_bpm_valid       (m_bpm_valid),
        .m_history_cleared (m_history_cleared),
        .m_interval_count  (m_interval_count),
        .m_saturated       (m_saturated),
        .cfg_wen           (cfg_wen),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    tte_tempo_checker u_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_tap_time        (s_tap_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_bpm_q8          (m_bpm_q8),
        .m_bpm_valid       (m_bpm_valid),
        .m_history_cleared (m_history_cleared),
        .m_interval_count  (m_interval_count),
        .m_saturated       (m_saturated),
        .cfg_wen           (cfg_wen),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .n_errors          (n_errors),
        .n_pending         (n_pending),
        .n_taps            (n_taps),
        .n_sat             (n_sat),
        .n_clear           (n_clear)
    );

    // Result side backpressure: mostly ready, short stalls, now and then a
    // long one so a finished tap waits in the output register while the
    // next one is already in the divider.
    always @(posedge aclk) begin
        int pick;
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                m_ready <= 1'b1;
                rx_hold = $urandom_range(0, 8);
            end else if (pick < 93) begin
                m_ready <= 1'b0;
                rx_hold = $urandom_range(0, 3);
            end else begin
                m_ready <= 1'b0;
                rx_hold = $urandom_range(10, 120);
            end
        end
    end

    // One tap transfer. An optional gap first; with no gap s_valid stays high
    // and only the payload moves on, so the input runs back to back.
    task automatic send_tap(input logic [31:0] t);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 3);
        end else if (r < 98) begin
            gap = $urandom_range(4, 20);
        end else begin
            gap = $urandom_range(21, 80);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_tap_time <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop sending and wait until every tap has produced its result transfer.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
    endtask

    // Registers change only with the block idle. Both registers are written
    // back to back, followed by a write to an unmapped index.
    task automatic program_regs(input logic [11:0] ss_w, input logic [11:0] rs_w);
        drain();
        cfg_wen   <= 1'b1;
        cfg_index <= tte_pkg::CFG_SAMPLE_SIZE;
        cfg_wdata <= ss_w;
        @(posedge aclk);
        cfg_index <= tte_pkg::CFG_RESET_SECONDS;
        cfg_wdata <= rs_w;
        @(posedge aclk);
        cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B;
        cfg_wdata <= 12'($urandom);
        @(posedge aclk);
        cfg_wen  <= 1'b0;
        clear_us = ((rs_w == 0) ? 32'd1 : 32'(rs_w)) * 32'd1000000;
        settings++;
    endtask

    initial begin
        logic [31:0] t;
        logic [31:0] beat;
        logic [31:0] step;
        logic [11:0] ss_w;
        logic [11:0] rs_w;
        bit          calm;
        int          r;

        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_tap_time <= '0;
        cfg_wen    <= 1'b0;
        cfg_index  <= tte_pkg::CFG_SAMPLE_SIZE;
        cfg_wdata  <= '0;
        clear_us   = 32'd5000000;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed: reset settings (window 5, timeout 5 s) ----
        send_tap(32'h0000_0000);   // first tap: nothing to average
        send_tap(32'h0000_0000);   // same timestamp: zero elapsed, saturates
        send_tap(32'd500000);      // two intervals over 0.5 s
        send_tap(32'd5500000);     // exactly at the timeout: history kept
        send_tap(32'd10500001);    // one us past the timeout: cleared
        send_tap(32'd10500002);    // 1 us interval: quotient overflows
        send_tap(32'hFFFF_F000);   // far jump clears again
        send_tap(32'h0000_1000);   // interval across the 32-bit wrap
        send_tap(32'hFFFF_FFFF);   // all-ones timestamp

        // zero in both registers reads as one tap / one second
        program_regs(12'd0, 12'd0);
        send_tap(32'h8000_0000);
        send_tap(32'h800F_4240);   // +1 s exactly
        send_tap(32'h801E_8480);   // window of one: k stays 1
        send_tap(32'h802D_C6C1);   // +1 s + 1 us: cleared

        // sample size beyond the depth is capped, longest timeout
        program_regs(12'hFFF, 12'hFFF);
        t = 32'h802D_C6C1;
        for (int n = 0; n < 6; n++) begin
            t = t + 32'd600000;
            send_tap(t);
        end

        // shrink the window with seven taps stored: trimmed after the next tap
        program_regs(12'd2, 12'hFFF);
        for (int n = 0; n < 2; n++) begin
            t = t + 32'd600000;
            send_tap(t);
        end

        // ---- random phases: steady tempo runs mixed with disruptions ----
        t    = $urandom;
        beat = 32'd500000;
        for (int p = 0; p < 16; p++) begin
            case (p)
                0: begin
                    ss_w = 12'd64;
                    rs_w = 12'd4000;
                end
                1: begin
                    ss_w = 12'd1;
                    rs_w = 12'd1;
                end
                2: begin
                    ss_w = 12'hFFF;
                    rs_w = 12'hFFF;
                end
                3: begin
                    ss_w = 12'd0;
                    rs_w = 12'd0;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0: ss_w = 12'($urandom_range(0, 2));
                        1: ss_w = 12'($urandom_range(62, 64));
                        2: ss_w = 12'($urandom_range(65, 127));
                        3: ss_w = 12'($urandom);    // upper bits are dropped
                        default: ss_w = 12'($urandom_range(3, 16));
                    endcase
                    case ($urandom_range(0, 4))
                        0: rs_w = 12'($urandom_range(0, 2));
                        1: rs_w = 12'($urandom_range(3999, 4095));
                        2: rs_w = 12'($urandom);
                        default: rs_w = 12'($urandom_range(3, 10));
                    endcase
                end
            endcase
            program_regs(ss_w, rs_w);
            idle_on = (p % 4 != 3);
            calm    = (p % 2 == 0);   // calm phases fill the window deeply

            for (int n = 0; n < 64; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // new tempo: mostly musical, sometimes near the overflow edge
                    if ($urandom_range(0, 4) == 0) begin
                        beat = 32'($urandom_range(600, 5000));
                    end else begin
                        beat = 32'($urandom_range(250000, 2000000));
                    end
                end
                r = $urandom_range(0, 99);
                if (calm && $urandom_range(0, 7) != 0) begin
                    r = 0;
                end
                if (r < 75) begin
                    step = beat + 32'($urandom_range(0, beat / 16)) - beat / 32;
                end else if (r < 82) begin
                    step = 32'($urandom_range(1, 2000));   // far too fast: may saturate
                end else if (r < 84) begin
                    step = 32'd0;
                end else if (r < 89) begin
                    step = clear_us + 32'($urandom_range(0, 1));   // timeout edge
                end else begin
                    step = clear_us + 32'($urandom_range(2, 20000000));
                end
                if (r < 95) begin
                    t = t + step;
                end else begin
                    t = $urandom;   // stray timestamp
                end
                send_tap(t);
            end
        end

        drain();
        repeat (64) @(posedge aclk);   // catch any stray result transfer
        $display("Covered %0d taps over %0d register settings plus reset defaults:",
                 n_taps, settings);
        $display("  %0d saturated results, %0d history clears.", n_sat, n_clear);
        if (n_errors == 0 && n_pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #12_000_000;
        $display("Timeout: run did not complete");
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### tap_tempo_bpm_estimator.f
design/tte_pkg.sv
design/tte_hist_mem.sv
design/tte_divider.sv
design/tap_tempo_bpm_estimator.sv
test/tte_tempo_checker.sv
test/tb_tap_tempo_bpm_estimator.sv
